// ----- rtl/ows_pkg.sv -----
package ows_pkg;

    typedef enum logic [1:0] {
        MODE_FORWARD  = 2'd0,
        MODE_BACKWARD = 2'd1,
        MODE_ROTATE   = 2'd2,
        MODE_WAIT     = 2'd3
    } mode_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_FORWARD_THRUST    = 3'd0;
    localparam logic [2:0] REG_OBSTACLE_DISTANCE = 3'd1;
    localparam logic [2:0] REG_HEIGHT_TARGET     = 3'd2;
    localparam logic [2:0] REG_REVERSE_TIME_MS   = 3'd3;
    localparam logic [2:0] REG_SETTLE_TIME_MS    = 3'd4;

    localparam logic [31:0] SWITCH_TIME_MS = 32'd10000;
    localparam logic [15:0] TIME_RESET_MS  = 16'd2000;
    localparam logic [3:0]  ZIGZAG_LIMIT   = 4'd8;

    // binary angles, 65536 per turn
    localparam logic [15:0] ANG_278 = 16'd50608;
    localparam logic [15:0] ANG_98  = 16'd17840;
    localparam logic [15:0] ANG_10  = 16'd1820;
    localparam logic [15:0] ANG_295 = 16'd53703;

    typedef struct packed {
        logic signed [15:0] forward_thrust;
        logic [11:0]        obstacle_distance;
        logic [15:0]        height_target;
        logic [15:0]        reverse_time_ms;
        logic [15:0]        settle_time_ms;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] mode_start_ms;
        logic [3:0]  zigzag_count;
        logic        zigzag_negative;
        logic [15:0] heading_target;
    } state_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] yaw_angle;
        logic [11:0]        range_sample;
    } item_t;

    typedef struct packed {
        mode_t              mode_out;
        logic [15:0]        heading_out;
        logic [15:0]        height_out;
        logic signed [15:0] thrust_out;
    } result_t;

endpackage

// ----- rtl/ows_step.sv -----
module ows_step (
    input  ows_pkg::cfg_t    cfg,
    input  ows_pkg::state_t  state,
    input  ows_pkg::item_t   item,
    output ows_pkg::state_t  state_next,
    output ows_pkg::result_t result
);

    logic [31:0]        elapsed;
    ows_pkg::mode_t     mode_next;
    logic [4:0]         zz_inc;
    logic [15:0]        step;
    logic signed [17:0] back_sum;
    logic signed [17:0] back_neg;
    logic signed [15:0] back_sat;

    assign elapsed = item.now_ms - state.mode_start_ms;

    // next mode
    always_comb begin
        mode_next = state.mode;
        case (state.mode)
            ows_pkg::MODE_FORWARD: begin
                if ((item.range_sample < cfg.obstacle_distance)
                        || (elapsed > ows_pkg::SWITCH_TIME_MS)) begin
                    mode_next = ows_pkg::MODE_BACKWARD;
                end
            end
            ows_pkg::MODE_BACKWARD: begin
                if (elapsed > {16'd0, cfg.reverse_time_ms}) begin
                    mode_next = ows_pkg::MODE_ROTATE;
                end
            end
            ows_pkg::MODE_ROTATE: begin
                mode_next = ows_pkg::MODE_WAIT;
            end
            ows_pkg::MODE_WAIT: begin
                if (elapsed > {16'd0, cfg.settle_time_ms}) begin
                    mode_next = ows_pkg::MODE_FORWARD;
                end
            end
            default: begin
                mode_next = ows_pkg::MODE_FORWARD;
            end
        endcase
    end

    // backward force: -(f + floor(f/2)), saturated to 16 bits
    always_comb begin
        back_sum = {{2{cfg.forward_thrust[15]}}, cfg.forward_thrust}
                 + {{3{cfg.forward_thrust[15]}}, cfg.forward_thrust[15:1]};
        back_neg = 18'sd0 - back_sum;
        if (back_neg > 18'sd32767) begin
            back_sat = 16'sh7FFF;
        end else if (back_neg < -18'sd32768) begin
            back_sat = 16'sh8000;
        end else begin
            back_sat = back_neg[15:0];
        end
    end

    // state update and result
    always_comb begin
        state_next      = state;
        state_next.mode = mode_next;
        zz_inc          = {1'b0, state.zigzag_count} + 5'd1;
        step            = state.zigzag_negative ? (16'd0 - ows_pkg::ANG_10) : ows_pkg::ANG_10;

        // wait keeps the timer that rotate started
        if ((mode_next != state.mode) && (mode_next != ows_pkg::MODE_WAIT)) begin
            state_next.mode_start_ms = item.now_ms;
        end

        if ((state.mode == ows_pkg::MODE_FORWARD) && (mode_next == ows_pkg::MODE_BACKWARD)) begin
            if (zz_inc > {1'b0, ows_pkg::ZIGZAG_LIMIT}) begin
                state_next.zigzag_count    = 4'd0;
                state_next.zigzag_negative = ~state.zigzag_negative;
            end else begin
                state_next.zigzag_count = zz_inc[3:0];
            end
        end

        if (mode_next == ows_pkg::MODE_ROTATE) begin
            if (item.yaw_angle > 16'sd0) begin
                state_next.heading_target = ows_pkg::ANG_278 + step;
            end else begin
                state_next.heading_target = ows_pkg::ANG_98 - step;
            end
        end

        result.mode_out    = mode_next;
        result.heading_out = state_next.heading_target;
        result.height_out  = cfg.height_target;
        case (mode_next)
            ows_pkg::MODE_FORWARD:  result.thrust_out = cfg.forward_thrust;
            ows_pkg::MODE_BACKWARD: result.thrust_out = back_sat;
            default:                result.thrust_out = 16'sd0;
        endcase
    end

endmodule

// ----- rtl/obstacle_walk_sequencer.sv -----
// Obstacle walk sequencer. Each input word is one control call (range sample,
// yaw, millisecond time); each output word is the command it yields (thrust,
// height, heading, mode). A word is held in the input register, is evaluated
// against the mode state in a single combinational step, and lands in the
// output register; the block takes one word every cycle as long as the
// output side keeps taking results; the state update of one call is in
// place before the next call is evaluated. Configuration writes take
// effect on the next edge and belong between traffic, when both registers
// are empty.
module obstacle_walk_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] range_sample, [27:12] yaw_angle, [59:28] now_ms, [63:60] zero
    input  logic [63:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] thrust_out, [31:16] height_out, [47:32] heading_out,
    // [49:48] mode_out, [55:50] zero
    output logic [55:0] m_tdata
);

    ows_pkg::cfg_t    cfg_reg;
    ows_pkg::state_t  state_reg;
    ows_pkg::state_t  state_next;
    ows_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    ows_pkg::result_t out_result_reg;
    ows_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             advance;
    logic             fire;

    // output register frees up when empty or being taken this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg};

    // configuration registers; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.forward_thrust    <= 16'sd0;
            cfg_reg.obstacle_distance <= 12'd0;
            cfg_reg.height_target     <= 16'd0;
            cfg_reg.reverse_time_ms   <= ows_pkg::TIME_RESET_MS;
            cfg_reg.settle_time_ms    <= ows_pkg::TIME_RESET_MS;
        end else if (cfg_we) begin
            case (cfg_addr)
                ows_pkg::REG_FORWARD_THRUST:    cfg_reg.forward_thrust    <= cfg_wdata;
                ows_pkg::REG_OBSTACLE_DISTANCE: cfg_reg.obstacle_distance <= cfg_wdata[11:0];
                ows_pkg::REG_HEIGHT_TARGET:     cfg_reg.height_target     <= cfg_wdata;
                ows_pkg::REG_REVERSE_TIME_MS:   cfg_reg.reverse_time_ms   <= cfg_wdata;
                ows_pkg::REG_SETTLE_TIME_MS:    cfg_reg.settle_time_ms    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register: hold until the step can advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_tdata[59:0];
        end
    end

    ows_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // mode state: advance only when a call actually moves to the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode            <= ows_pkg::MODE_FORWARD;
            state_reg.mode_start_ms   <= 32'd0;
            state_reg.zigzag_count    <= 4'd0;
            state_reg.zigzag_negative <= 1'b0;
            state_reg.heading_target  <= ows_pkg::ANG_295;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= result_next;
        end
    end

    // the zig-zag counter wraps before it passes the limit
    a_zigzag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.zigzag_count <= ows_pkg::ZIGZAG_LIMIT)
        else $error("zigzag count beyond limit");

    // rotate lasts exactly one processed call
    a_rotate_one_call: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (state_reg.mode == ows_pkg::MODE_ROTATE)
        |=> state_reg.mode == ows_pkg::MODE_WAIT)
        else $error("rotate held past one call");

    // heading only moves on entry into rotate
    a_heading_on_rotate: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (state_reg.heading_target != $past(state_reg.heading_target))
        |-> state_reg.mode == ows_pkg::MODE_ROTATE)
        else $error("heading changed outside rotate");

    // a delivered rotate or wait command carries no thrust
    a_idle_thrust: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && ((out_result_reg.mode_out == ows_pkg::MODE_ROTATE)
            || (out_result_reg.mode_out == ows_pkg::MODE_WAIT))
        |-> out_result_reg.thrust_out == 16'sd0)
        else $error("thrust in rotate or wait");

    // an empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule

// ----- tb/walk_command_checker.sv -----
module walk_command_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    input  logic        s_tready,
    // [11:0] range_sample, [27:12] yaw_angle, [59:28] now_ms, [63:60] zero
    input  logic [63:0] s_tdata,

    input  logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] thrust_out, [31:16] height_out, [47:32] heading_out,
    // [49:48] mode_out, [55:50] zero
    input  logic [55:0] m_tdata,

    output int          mismatches,
    output int          outstanding
);

    ows_pkg::cfg_t    cfg;
    ows_pkg::mode_t   walk_mode;
    logic [31:0]      mode_start;
    logic [3:0]       zz_count;
    logic             zz_negative;
    logic [15:0]      heading;
    ows_pkg::result_t expected_cmds[$];
    int               fail_count = 0;

    // Advance the walk by one control call and return the command it yields.
    function automatic ows_pkg::result_t advance_walk(ows_pkg::item_t call);
        logic [31:0]        elapsed;
        logic [4:0]         zz_next;
        logic [15:0]        swing;
        logic signed [17:0] wide_f;
        logic signed [17:0] reverse_f;
        ows_pkg::result_t   cmd;
        elapsed = call.now_ms - mode_start;
        case (walk_mode)
            ows_pkg::MODE_FORWARD: begin
                if (call.range_sample < cfg.obstacle_distance
                        || elapsed > ows_pkg::SWITCH_TIME_MS) begin
                    walk_mode  = ows_pkg::MODE_BACKWARD;
                    mode_start = call.now_ms;
                    zz_next    = {1'b0, zz_count} + 5'd1;
                    if (zz_next > {1'b0, ows_pkg::ZIGZAG_LIMIT}) begin
                        zz_next     = '0;
                        zz_negative = ~zz_negative;
                    end
                    zz_count = zz_next[3:0];
                end
            end
            ows_pkg::MODE_BACKWARD: begin
                if (elapsed > {16'd0, cfg.reverse_time_ms}) begin
                    walk_mode  = ows_pkg::MODE_ROTATE;
                    mode_start = call.now_ms;
                end
            end
            ows_pkg::MODE_ROTATE: begin
                walk_mode = ows_pkg::MODE_WAIT;
            end
            default: begin
                if (elapsed > {16'd0, cfg.settle_time_ms}) begin
                    walk_mode  = ows_pkg::MODE_FORWARD;
                    mode_start = call.now_ms;
                end
            end
        endcase

        cmd.thrust_out = '0;
        case (walk_mode)
            ows_pkg::MODE_FORWARD: begin
                cmd.thrust_out = cfg.forward_thrust;
            end
            ows_pkg::MODE_BACKWARD: begin
                // -(f + floor(f/2)), clipped to 16 bit signed
                wide_f    = $signed(cfg.forward_thrust);
                reverse_f = -(wide_f + (wide_f >>> 1));
                if (reverse_f > 18'sd32767)
                    cmd.thrust_out = 16'sh7FFF;
                else if (reverse_f < -18'sd32768)
                    cmd.thrust_out = 16'sh8000;
                else
                    cmd.thrust_out = reverse_f[15:0];
            end
            ows_pkg::MODE_ROTATE: begin
                swing = zz_negative ? (16'd0 - ows_pkg::ANG_10) : ows_pkg::ANG_10;
                if ($signed(call.yaw_angle) > 0)
                    heading = ows_pkg::ANG_278 + swing;
                else
                    heading = ows_pkg::ANG_98 - swing;
            end
            default: ;
        endcase
        cmd.height_out  = cfg.height_target;
        cmd.heading_out = heading;
        cmd.mode_out    = walk_mode;
        return cmd;
    endfunction

    always @(posedge aclk) begin : track
        ows_pkg::item_t   call;
        ows_pkg::result_t got;
        ows_pkg::result_t want;
        if (!aresetn) begin
            cfg.forward_thrust    = '0;
            cfg.obstacle_distance = '0;
            cfg.height_target     = '0;
            cfg.reverse_time_ms   = ows_pkg::TIME_RESET_MS;
            cfg.settle_time_ms    = ows_pkg::TIME_RESET_MS;
            walk_mode   = ows_pkg::MODE_FORWARD;
            mode_start  = '0;
            zz_count    = '0;
            zz_negative = 1'b0;
            heading     = ows_pkg::ANG_295;
            expected_cmds.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    ows_pkg::REG_FORWARD_THRUST:    cfg.forward_thrust    = cfg_wdata;
                    ows_pkg::REG_OBSTACLE_DISTANCE: cfg.obstacle_distance = cfg_wdata[11:0];
                    ows_pkg::REG_HEIGHT_TARGET:     cfg.height_target     = cfg_wdata;
                    ows_pkg::REG_REVERSE_TIME_MS:   cfg.reverse_time_ms   = cfg_wdata;
                    ows_pkg::REG_SETTLE_TIME_MS:    cfg.settle_time_ms    = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[49:0];
                if (expected_cmds.size() == 0) begin
                    $error("command word with no control call pending");
                    fail_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.thrust_out !== want.thrust_out) begin
                        $error("thrust_out: expected %0d, got %0d",
                               $signed(want.thrust_out), $signed(got.thrust_out));
                        fail_count++;
                    end
                    if (got.height_out !== want.height_out) begin
                        $error("height_out: expected %0d, got %0d",
                               want.height_out, got.height_out);
                        fail_count++;
                    end
                    if (got.heading_out !== want.heading_out) begin
                        $error("heading_out: expected %0d, got %0d",
                               want.heading_out, got.heading_out);
                        fail_count++;
                    end
                    if (got.mode_out !== want.mode_out) begin
                        $error("mode_out: expected %0d, got %0d",
                               want.mode_out, got.mode_out);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                call = s_tdata[59:0];
                expected_cmds.push_back(advance_walk(call));
            end
        end
        mismatches  <= fail_count;
        outstanding <= expected_cmds.size();
    end

endmodule

// ----- tb/obstacle_walk_sequencer_test.sv -----
module obstacle_walk_sequencer_test;

    // indexes past the last register; writes there must change nothing
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    localparam int PHASES          = 9;
    localparam int CALLS_PER_PHASE = 126;
    localparam int HOLD_CYCLES     = 90;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;

    int          mismatches;
    int          outstanding;

    // pacing knobs, percent of cycles each side sits idle
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    logic        hold_request = 1'b0;
    logic        hold_served  = 1'b0;
    int          hold_left    = 0;

    // running millisecond clock seen by the block
    logic [31:0] clock_ms = '0;

    always #6 aclk = ~aclk;

    obstacle_walk_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    walk_command_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: random ready, plus one long hold-off whenever the stimulus
    // raises hold_request, so the block fills up and pushes back on its input.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
            m_tready    <= 1'b0;
        end else begin
            if (!hold_request)
                hold_served <= 1'b0;
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Write one register; leave cfg_we high so back-to-back writes never
    // drop and raise it in the same step. The caller lowers it afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Offer one control call after a random gap; return once it is taken.
    task automatic offer_call(input logic [11:0] rng, input logic [15:0] yaw,
                              input logic [31:0] ms);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ms, yaw, rng};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Stop offering and wait until every command word has come back.
    task automatic drain_commands();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          p;
        int          k;
        int          pick;
        logic [31:0] step;
        logic [11:0] rng;
        logic [15:0] yaw;
        logic [15:0] thrust;
        logic [15:0] rev_ms;
        logic [15:0] settle_ms;
        logic [11:0] near_limit;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk one full cycle on the reset timings, with edge cases on time:
        // elapsed equal to a limit must not switch, one more must.
        write_reg(ows_pkg::REG_FORWARD_THRUST, 16'h5555);
        write_reg(ows_pkg::REG_HEIGHT_TARGET, 16'hFFFF);
        cfg_we <= 1'b0;
        tx_idle_pct <= 33;
        rx_idle_pct <= 46;
        offer_call(12'hFFF, 16'h7FFF, 32'd0);
        offer_call(12'h000, 16'hFFFF, 32'd10000);
        offer_call(12'hFFF, 16'h0000, 32'd10001);
        offer_call(12'h000, 16'h0001, 32'd12001);
        // half-turn yaw counts as not positive
        offer_call(12'h800, 16'h8000, 32'd12002);
        offer_call(12'h001, 16'h7FFF, 32'd12003);
        offer_call(12'hFFF, 16'h0001, 32'd14002);
        offer_call(12'hFFF, 16'h0001, 32'd14003);
        // time wraps past 2^32 while backing up
        offer_call(12'hFFF, 16'h7FFF, 32'hFFFF_F000);
        offer_call(12'hFFF, 16'h0001, 32'h0000_0300);
        offer_call(12'hFFF, 16'h0001, 32'h0000_0301);
        offer_call(12'hFFF, 16'h0001, 32'h0000_0AD1);
        drain_commands();

        // Saturating backward force, zero timings, obstacle at full distance.
        write_reg(ows_pkg::REG_FORWARD_THRUST, 16'h8000);
        write_reg(ows_pkg::REG_OBSTACLE_DISTANCE, 16'hFFFF);
        write_reg(REG_UNMAPPED_HI, 16'($urandom));
        write_reg(ows_pkg::REG_REVERSE_TIME_MS, 16'h0000);
        write_reg(ows_pkg::REG_SETTLE_TIME_MS, 16'h0000);
        cfg_we <= 1'b0;
        offer_call(12'hFFE, 16'h0000, 32'h0000_0AD6);
        offer_call(12'hFFF, 16'h0000, 32'h0000_0AD6);
        offer_call(12'hFFF, 16'h0000, 32'h0000_0AD7);
        offer_call(12'hFFF, 16'h0000, 32'h0000_0AD7);
        offer_call(12'hFFF, 16'h0000, 32'h0000_0AD8);
        clock_ms = 32'h0000_0AD8;
        drain_commands();

        for (p = 0; p < PHASES; p++) begin
            // receiver-heavy idling, then sender-heavy, then none
            if (p < 3) begin
                tx_idle_pct <= 33;
                rx_idle_pct <= 46;
            end else if (p < 6) begin
                tx_idle_pct <= 46;
                rx_idle_pct <= 33;
            end else begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end

            case (p)
                0:       thrust = 16'h5555;
                1:       thrust = 16'hAAAB;
                2:       thrust = 16'h7FFF;
                3:       thrust = 16'h8000;
                4:       thrust = 16'hAAAA;
                5:       thrust = 16'h0001;
                6:       thrust = 16'hFFFF;
                7:       thrust = 16'h0000;
                default: thrust = 16'($urandom);
            endcase
            case (p % 3)
                0:       near_limit = 12'h000;
                1:       near_limit = 12'hFFF;
                default: near_limit = 12'($urandom_range(4095));
            endcase
            case (p % 4)
                0:       rev_ms = 16'($urandom_range(40));
                1:       rev_ms = 16'($urandom_range(1000, 3000));
                2:       rev_ms = (p == 2) ? 16'hFFFF : 16'($urandom);
                default: rev_ms = 16'h0000;
            endcase
            case ((p + 1) % 4)
                0:       settle_ms = 16'($urandom_range(40));
                1:       settle_ms = 16'($urandom_range(1000, 3000));
                2:       settle_ms = (p == 1) ? 16'hFFFF : 16'($urandom);
                default: settle_ms = 16'h0000;
            endcase

            write_reg(ows_pkg::REG_FORWARD_THRUST, thrust);
            // junk in the bits above the 12-bit distance
            write_reg(ows_pkg::REG_OBSTACLE_DISTANCE, {4'($urandom), near_limit});
            write_reg(REG_UNMAPPED_LO + 3'(p % 3), 16'($urandom));
            write_reg(ows_pkg::REG_HEIGHT_TARGET, (p == 0) ? 16'h0000 :
                                                  (p == 1) ? 16'hFFFF : 16'($urandom));
            write_reg(ows_pkg::REG_REVERSE_TIME_MS, rev_ms);
            write_reg(ows_pkg::REG_SETTLE_TIME_MS, settle_ms);
            cfg_we <= 1'b0;

            // hold the result side off for a long stretch in two phases
            hold_request <= (p == 1 || p == 7);

            for (k = 0; k < CALLS_PER_PHASE; k++) begin
                // mostly a clock moving forward, crawling or striding,
                // sometimes a jump anywhere or a step back in time
                pick = $urandom_range(99);
                if (pick < 40)
                    step = $urandom_range(3);
                else if (pick < 80)
                    step = $urandom_range(2500);
                else if (pick < 92)
                    step = $urandom_range(2500, 12000);
                else if (pick < 97)
                    step = $urandom;
                else
                    step = 32'd0 - $urandom_range(1, 5000);
                clock_ms = clock_ms + step;

                if ($urandom_range(9) == 0)
                    rng = $urandom_range(1) ? 12'hFFF : 12'h000;
                else
                    rng = 12'($urandom_range(4095));
                case ($urandom_range(9))
                    0:       yaw = 16'h8000;
                    1:       yaw = 16'h0000;
                    2:       yaw = 16'h7FFF;
                    default: yaw = 16'($urandom);
                endcase
                offer_call(rng, yaw, clock_ms);
            end
            hold_request <= 1'b0;
            drain_commands();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("obstacle_walk_sequencer_test passed");
        end else begin
            if (outstanding != 0)
                $error("%0d command words never arrived", outstanding);
            $display("obstacle_walk_sequencer_test failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #(12 * 400000);
        $display("obstacle_walk_sequencer_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ows_pkg.sv
rtl/ows_step.sv
rtl/obstacle_walk_sequencer.sv
tb/walk_command_checker.sv
tb/obstacle_walk_sequencer_test.sv
